>>> src/rptd_pkg.sv
// ----------------------------------------------------------------------------
// rptd_pkg
// Shared constants, types and helpers for the raster pixel to thermal dot
// packer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rptd_pkg;

    // Column counter width and the compare width that also covers line_width.
    localparam int COLUMN_BITS    = 16;
    localparam int LINE_BITS      = 16;
    localparam int CMP_BITS       = (COLUMN_BITS + 1 > LINE_BITS) ? COLUMN_BITS + 1 : LINE_BITS;

    // Configuration port geometry.
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 16;

    // Register indexes.
    localparam logic [CFG_INDEX_BITS-1:0] REG_COLOR_SPACE     = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_PACKED_MODE     = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_COMPONENT_COUNT = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_LINE_WIDTH      = 2'd3;

    // Color space codes.
    localparam logic [3:0] CS_K    = 4'd0;
    localparam logic [3:0] CS_GRAY = 4'd1;
    localparam logic [3:0] CS_RGB  = 4'd2;
    localparam logic [3:0] CS_CMY  = 4'd3;
    localparam logic [3:0] CS_YMC  = 4'd4;
    localparam logic [3:0] CS_CMYK = 4'd5;
    localparam logic [3:0] CS_YMCK = 4'd6;
    localparam logic [3:0] CS_KCMY = 4'd7;

    // Weighted luma sums fit in 18 bits (at most 1000 * 255).
    localparam int SUM_BITS = 18;
    localparam logic [SUM_BITS-1:0] RGB_BLACK_LIMIT = 18'd128000;
    // Rounded ink of at least 128 means sum + 500 >= 128000.
    localparam logic [SUM_BITS-1:0] INK_BLACK_LIMIT = 18'd127500;

    localparam logic [7:0] WHITE_BYTE = 8'hff;
    localparam logic [7:0] LEFT_DOT   = 8'h80;

    // Configuration seen by the classifier.
    typedef struct packed {
        logic [3:0] space_code;
        logic       packed_mode;
        logic [3:0] component_count;
    } t_pix_cfg;

    // Weighted sum 299a + 587b + 114c.
    function automatic logic [SUM_BITS-1:0] luma_sum(input logic [7:0] a,
                                                     input logic [7:0] b,
                                                     input logic [7:0] c);
        logic [SUM_BITS-1:0] pa;
        logic [SUM_BITS-1:0] pb;
        logic [SUM_BITS-1:0] pc;
        pa = SUM_BITS'(a) * 18'd299;
        pb = SUM_BITS'(b) * 18'd587;
        pc = SUM_BITS'(c) * 18'd114;
        return pa + pb + pc;
    endfunction

endpackage

`default_nettype wire

>>> src/rptd_classify.sv
// ----------------------------------------------------------------------------
// rptd_classify
// Decides whether one pixel prints black under the configured color space.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rptd_classify
    import rptd_pkg::*;
(
    input  wire t_pix_cfg   i_cfg,
    input  wire logic [7:0] i_s0,
    input  wire logic [7:0] i_s1,
    input  wire logic [7:0] i_s2,
    input  wire logic [7:0] i_s3,
    output logic            o_black
);

    logic [SUM_BITS-1:0] sum_fwd;
    logic [SUM_BITS-1:0] sum_rev;
    logic [SUM_BITS-1:0] sum_kcmy;
    logic                has3;
    logic                has4;
    logic                byte_black;

    // The three weightings the color spaces need.
    assign sum_fwd  = luma_sum(i_s0, i_s1, i_s2);
    assign sum_rev  = luma_sum(i_s2, i_s1, i_s0);
    assign sum_kcmy = luma_sum(i_s1, i_s2, i_s3);

    assign has3 = (i_cfg.component_count >= 4'd3);
    assign has4 = (i_cfg.component_count >= 4'd4);

    // Byte mode rules. The larger of ink and K reaches 128 when either does.
    always_comb begin
        case (i_cfg.space_code)
            CS_K:    byte_black = i_s0[7];
            CS_GRAY: byte_black = !i_s0[7];
            CS_RGB:  byte_black = has3 && (sum_fwd < RGB_BLACK_LIMIT);
            CS_CMY:  byte_black = has3 && (sum_fwd >= INK_BLACK_LIMIT);
            CS_YMC:  byte_black = has3 && (sum_rev >= INK_BLACK_LIMIT);
            CS_CMYK: byte_black = has4 && ((sum_fwd >= INK_BLACK_LIMIT) || i_s3[7]);
            CS_YMCK: byte_black = has4 && ((sum_rev >= INK_BLACK_LIMIT) || i_s3[7]);
            CS_KCMY: byte_black = has4 && ((sum_kcmy >= INK_BLACK_LIMIT) || i_s0[7]);
            default: byte_black = (i_cfg.component_count == 4'd1) && !i_s0[7];
        endcase
    end

    // Packed mode: a set bit is black, except in additive gray.
    always_comb begin
        if (i_cfg.packed_mode) begin
            o_black = (i_cfg.space_code == CS_GRAY) ? !i_s0[0] : i_s0[0];
        end else begin
            o_black = byte_black;
        end
    end

endmodule

`default_nettype wire

>>> src/raster_pixel_to_thermal_dots_core.sv
// ----------------------------------------------------------------------------
// raster_pixel_to_thermal_dots_core
// Turns a stream of raster pixels into packed thermal dot bytes.
// ----------------------------------------------------------------------------
// One pixel word is accepted per clock. A pixel is captured in an input
// register, classified black or white in the next cycle and merged into the
// dot byte being built, MSB first, 1 for white. Every eighth pixel, or the
// last pixel of a line, loads the output register with the byte and its
// line_end flag. The packer advances once per cycle, so throughput is one
// pixel per clock as long as the output side takes each byte; a byte left
// waiting stalls the input only when the next pixel would produce another
// byte. Configuration is written through a simple write port; the user must
// write it only while the block idles, which the block does not enforce.
`timescale 1ns / 1ps
`default_nettype none

module raster_pixel_to_thermal_dots_core
    import rptd_pkg::*;
(
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    // configuration write port
    input  wire logic                      i_cfg_we,
    input  wire logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0]  i_cfg_data,
    // pixel input
    input  wire logic                      i_in_valid,
    output logic                           o_in_ready,
    input  wire logic [7:0]                i_sample_zero,
    input  wire logic [7:0]                i_sample_one,
    input  wire logic [7:0]                i_sample_two,
    input  wire logic [7:0]                i_sample_three,
    // dot byte output
    output logic                           o_out_valid,
    input  wire logic                      i_out_ready,
    output logic [7:0]                     o_dot_byte,
    output logic                           o_line_end
);

    t_pix_cfg               r_cfg;
    logic [LINE_BITS-1:0]   r_line_width;

    logic                   r_s1_valid;
    logic [7:0]             r_s0;
    logic [7:0]             r_s1;
    logic [7:0]             r_s2;
    logic [7:0]             r_s3;

    logic [COLUMN_BITS-1:0] r_column;
    logic [COLUMN_BITS-1:0] n_column;
    logic [7:0]             r_partial;
    logic [7:0]             n_partial;

    logic                   r_out_valid;
    logic [7:0]             r_out_byte;
    logic                   r_out_line_end;

    logic                   black;
    logic                   last;
    logic                   emit;
    logic                   advance;
    logic [CMP_BITS-1:0]    col_next_wide;
    logic [7:0]             merged;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.space_code      <= CS_K;
            r_cfg.packed_mode     <= 1'b0;
            r_cfg.component_count <= 4'd1;
            r_line_width          <= LINE_BITS'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_COLOR_SPACE:     r_cfg.space_code      <= i_cfg_data[3:0];
                REG_PACKED_MODE:     r_cfg.packed_mode     <= i_cfg_data[0];
                REG_COMPONENT_COUNT: r_cfg.component_count <= i_cfg_data[3:0];
                REG_LINE_WIDTH:      r_line_width          <= i_cfg_data[LINE_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Classification of the captured pixel.
    rptd_classify u_classify (
        .i_cfg   (r_cfg),
        .i_s0    (r_s0),
        .i_s1    (r_s1),
        .i_s2    (r_s2),
        .i_s3    (r_s3),
        .o_black (black)
    );

    // Line end and byte boundary detection.
    assign col_next_wide = CMP_BITS'(r_column) + CMP_BITS'(1);
    assign last = (col_next_wide >= CMP_BITS'(r_line_width)) || (&r_column);
    assign emit = (r_column[2:0] == 3'd7) || last;
    assign merged = black ? (r_partial & ~(LEFT_DOT >> r_column[2:0])) : r_partial;

    // The captured pixel moves on unless it would overwrite a waiting byte.
    assign advance    = r_s1_valid && (!emit || !r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || advance;

    always_comb begin
        n_column  = r_column;
        n_partial = r_partial;
        if (advance) begin
            if (emit) begin
                n_partial = WHITE_BYTE;
                n_column  = last ? '0 : col_next_wide[COLUMN_BITS-1:0];
            end else begin
                n_partial = merged;
                n_column  = col_next_wide[COLUMN_BITS-1:0];
            end
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_s0 <= i_sample_zero;
            r_s1 <= i_sample_one;
            r_s2 <= i_sample_two;
            r_s3 <= i_sample_three;
        end
    end

    // Packing state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_column  <= '0;
            r_partial <= WHITE_BYTE;
        end else begin
            r_column  <= n_column;
            r_partial <= n_partial;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && emit) begin
            r_out_byte     <= merged;
            r_out_line_end <= last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_dot_byte  = r_out_byte;
    assign o_line_end  = r_out_line_end;

endmodule

`default_nettype wire

>>> src/rptd_checker.sv
// ----------------------------------------------------------------------------
// rptd_checker
// Port level checks for the thermal dot packer, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rptd_checker
    import rptd_pkg::*;
(
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_in_ready,
    input wire logic       o_out_valid,
    input wire logic       i_out_ready,
    input wire logic [7:0] o_dot_byte,
    input wire logic       o_line_end
);

    // A waiting word stays offered until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("output word dropped while stalled");

    // A waiting word keeps its payload.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_dot_byte) && $stable(o_line_end))
        else $error("output word changed while stalled");

    // The input only stalls behind a word that the output side refuses.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid && !i_out_ready)
        else $error("input stalled without output back pressure");

    // Nothing is offered right after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind raster_pixel_to_thermal_dots_core rptd_checker u_rptd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_dot_byte  (o_dot_byte),
    .o_line_end  (o_line_end)
);

`default_nettype wire
